// File: rtl/lcdai_pkg.sv
package lcdai_pkg;

  // Frame store geometry.
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // The linear byte address before wrapping stays below 2**10.
  localparam int SUM_W       = ((ADDR_W > 10) ? ADDR_W : 10) + 1;

  // Bus access kinds.
  localparam logic [1:0] CMD_CTRL  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Command code ranges.
  localparam logic [7:0] CODE_MODE_LO   = 8'h00;
  localparam logic [7:0] CODE_MODE_HI   = 8'h01;
  localparam logic [7:0] CODE_DIR_LO    = 8'h04;
  localparam logic [7:0] CODE_DIR_HI    = 8'h07;
  localparam logic [7:0] CODE_COL_LO    = 8'h20;
  localparam logic [7:0] CODE_COL_HI    = 8'h30;
  localparam logic [7:0] CODE_SCROLL_LO = 8'h40;
  localparam logic [7:0] CODE_SCROLL_HI = 8'h7F;
  localparam logic [7:0] CODE_ROW_LO    = 8'h80;
  localparam logic [7:0] CODE_ROW_HI    = 8'hBF;
  localparam logic [7:0] CODE_CONT_LO   = 8'hD8;
  localparam logic [7:0] CODE_CONT_HI   = 8'hFF;

  // Mask of a 6-bit word placed at the top of a byte.
  localparam logic [7:0] WORD_MASK = 8'hFC;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Step direction after reset: column increment.
  localparam logic [1:0] DIR_RESET = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BACK,
    S_ADDR,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_FWD2,
    S_FWD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [5:0] row;
    logic [3:0] col;
  } pos_t;

  // Move the cursor one position. Direction bit 1 picks column versus row,
  // bit 0 picks increment; fwd low walks the reverse way.
  function automatic pos_t step_pos(pos_t p, logic [1:0] dir, logic fwd);
    pos_t q;
    logic inc;
    q   = p;
    inc = (dir[0] == fwd);
    if (!dir[1]) begin
      q.row = inc ? p.row + 6'd1 : p.row - 6'd1;
    end else begin
      q.col = inc ? p.col + 4'd1 : p.col - 4'd1;
    end
    return q;
  endfunction

  // Fold a linear byte address into the store; it never reaches twice the depth.
  function automatic logic [ADDR_W-1:0] wrap_addr(logic [SUM_W-1:0] a);
    logic [SUM_W-1:0] d;
    d = a;
    if (a >= SUM_W'(STORE_DEPTH)) begin
      d = a - SUM_W'(STORE_DEPTH);
    end
    return d[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/lcd_driver_auto_increment_top.sv
// Monochrome LCD driver with an auto-incrementing cursor over a frame store
// of 12 bytes per row.
// Input channel: in_command (0 command write, 1 data write, 2 data read) and
// in_value, transferred when in_valid is high and in_stall is low.
// Result channel: one transfer per input item carrying out_read_data (the
// fetched byte on a read, zero otherwise), out_scroll_row and
// out_contrast_level, held while out_stall is high.
// A small sequencer drives one single-port frame memory and one cursor
// stepper, one memory access or one cursor step per cycle. A command goes to
// hand-off at once; a write computes the address, reads old bytes (not for an
// 8-bit write), writes one byte (two when a 6-bit word straddles bytes) and
// steps the cursor; a read steps back, reads two bytes and steps forward twice.
// Items are taken only in idle, to which the sequencer returns with the result.
// The output register frees the sequencer: a new item is taken while a
// result waits; a second result waits in the sequencer until the first
// transfers.
// After reset the frame memory is filled with 0xFF, one byte per cycle, over
// all 1024 addresses, with in_stall held high; the cursor, modes, scroll and
// contrast return to their reset values at once.
module lcd_driver_auto_increment_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [5:0] out_scroll_row,
  output logic [5:0] out_contrast_level
);
  import lcdai_pkg::*;

  state_t            state_r, state_nxt;
  pos_t              pos_r, pos_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic              wide_r, wide_nxt;
  logic [5:0]        scroll_r, scroll_nxt;
  logic [5:0]        contrast_r, contrast_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [7:0]        val_r, val_nxt;
  logic [SUM_W-1:0]  lin_r, lin_nxt;
  logic [2:0]        off_r, off_nxt;
  logic [ADDR_W-1:0] a0_r, a0_nxt;
  logic [ADDR_W-1:0] a1_r, a1_nxt;
  logic [7:0]        b0_r, b0_nxt;
  logic [7:0]        b1_r, b1_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_rd_r, out_rd_nxt;
  logic [5:0]        out_scroll_r, out_scroll_nxt;
  logic [5:0]        out_cont_r, out_cont_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic [SUM_W-1:0]  row12;
  logic [6:0]        bitpos;
  logic [SUM_W-1:0]  boff;
  logic [15:0]       wr_shift;
  logic [15:0]       wr_mask;
  logic [7:0]        new0;
  logic [7:0]        new1;
  logic [3:0]        rd_shamt;
  logic [23:0]       rd_pair;

  lcdai_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Cursor to linear address and bit offset.
  always_comb begin
    row12  = SUM_W'({pos_r.row, 3'b000}) + SUM_W'({pos_r.row, 2'b00});
    bitpos = 7'({pos_r.col, 2'b00}) + 7'({pos_r.col, 1'b0});
    boff   = wide_r ? SUM_W'(pos_r.col) : SUM_W'(bitpos[6:3]);
  end

  // Merge of a 6-bit word into one or two bytes, and the read-back window.
  always_comb begin
    wr_shift = {val_r[5:0], 2'b00, 8'h00} >> off_r;
    wr_mask  = {WORD_MASK, 8'h00} >> off_r;
    new0     = (b0_r & ~wr_mask[15:8]) | wr_shift[15:8];
    new1     = (b1_r & ~wr_mask[7:0]) | wr_shift[7:0];
    rd_shamt = 4'd10 - {1'b0, off_r};
    rd_pair  = {8'h00, b0_r, ram_rdata} >> rd_shamt;
  end

  // Sequencer: next state, datapath updates and memory port.
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    dir_nxt        = dir_r;
    wide_nxt       = wide_r;
    scroll_nxt     = scroll_r;
    contrast_nxt   = contrast_r;
    clr_cnt_nxt    = clr_cnt_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    lin_nxt        = lin_r;
    off_nxt        = off_r;
    a0_nxt         = a0_r;
    a1_nxt         = a1_r;
    b0_nxt         = b0_r;
    b1_nxt         = b1_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_rd_nxt     = out_rd_r;
    out_scroll_nxt = out_scroll_r;
    out_cont_nxt   = out_cont_r;
    ram_we         = 1'b0;
    ram_addr       = a0_r;
    ram_wdata      = new0;
    in_stall       = 1'b1;

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = FILL_BYTE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt  = in_command;
          val_nxt = in_value;
          rd_nxt  = 8'h00;
          case (in_command)
            CMD_CTRL: begin
              case (in_value) inside
                [CODE_MODE_LO:CODE_MODE_HI]:     wide_nxt     = in_value[0];
                [CODE_DIR_LO:CODE_DIR_HI]:       dir_nxt      = in_value[1:0];
                [CODE_COL_LO:CODE_COL_HI]:       pos_nxt.col  = in_value[3:0];
                [CODE_SCROLL_LO:CODE_SCROLL_HI]: scroll_nxt   = in_value[5:0];
                [CODE_ROW_LO:CODE_ROW_HI]:       pos_nxt.row  = in_value[5:0];
                [CODE_CONT_LO:CODE_CONT_HI]: begin
                  contrast_nxt = 6'(in_value - CODE_CONT_LO);
                end
                default: ;
              endcase
              state_nxt = S_OUT;
            end
            CMD_WRITE: state_nxt = S_ADDR;
            CMD_READ:  state_nxt = S_BACK;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_BACK: begin
        pos_nxt   = step_pos(pos_r, dir_r, 1'b0);
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        lin_nxt   = row12 + boff;
        off_nxt   = wide_r ? 3'd0 : bitpos[2:0];
        state_nxt = S_RD0;
      end
      S_RD0: begin
        // Fetch the first byte; an 8-bit write needs no old contents.
        a0_nxt    = wrap_addr(lin_r);
        ram_addr  = a0_nxt;
        state_nxt = (wide_r && op_r == CMD_WRITE) ? S_WR0 : S_RD1;
      end
      S_RD1: begin
        a1_nxt    = wrap_addr(lin_r + 1'b1);
        ram_addr  = a1_nxt;
        b0_nxt    = ram_rdata;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        b1_nxt = ram_rdata;
        if (op_r == CMD_READ) begin
          rd_nxt    = wide_r ? b0_r : rd_pair[7:0];
          state_nxt = S_FWD2;
        end else begin
          state_nxt = S_WR0;
        end
      end
      S_WR0: begin
        ram_we    = 1'b1;
        ram_addr  = a0_r;
        ram_wdata = wide_r ? val_r : new0;
        state_nxt = (!wide_r && off_r > 3'd2) ? S_WR1 : S_FWD;
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_addr  = a1_r;
        ram_wdata = new1;
        state_nxt = S_FWD;
      end
      S_FWD2: begin
        pos_nxt   = step_pos(pos_r, dir_r, 1'b1);
        state_nxt = S_FWD;
      end
      S_FWD: begin
        pos_nxt   = step_pos(pos_r, dir_r, 1'b1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = rd_r;
          out_scroll_nxt = scroll_r;
          out_cont_nxt   = contrast_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      dir_r       <= DIR_RESET;
      wide_r      <= 1'b0;
      scroll_r    <= '0;
      contrast_r  <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      wide_r      <= wide_nxt;
      scroll_r    <= scroll_nxt;
      contrast_r  <= contrast_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    lin_r        <= lin_nxt;
    off_r        <= off_nxt;
    a0_r         <= a0_nxt;
    a1_r         <= a1_nxt;
    b0_r         <= b0_nxt;
    b1_r         <= b1_nxt;
    rd_r         <= rd_nxt;
    out_rd_r     <= out_rd_nxt;
    out_scroll_r <= out_scroll_nxt;
    out_cont_r   <= out_cont_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rd_r;
  assign out_scroll_row     = out_scroll_r;
  assign out_contrast_level = out_cont_r;

  // The memory is never written while the sequencer waits for an item.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("frame memory written in idle");

  // Every accepted item starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted item did not start the sequencer");

  // A result only appears out of the hand-off state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside hand-off");

  // The second byte is written only for a 6-bit word that straddles bytes.
  a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |-> (!wide_r && off_r > 3'd2))
    else $error("second byte written without a straddling word");

  // The fill pass walks the memory one address per cycle once reset is released.
  a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r == S_CLEAR) |=>
      (state_r == S_IDLE || clr_cnt_r == ADDR_W'($past(clr_cnt_r) + 1'b1)))
    else $error("fill pass skipped an address");

endmodule

// File: rtl/lcdai_ram.sv
module lcdai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
